// ===== hw/rtl/bisf_pkg.sv =====
// shared widths, formats and constants for the inverse-square bisection fit
`default_nettype none
package bisf_pkg;

  // field widths
  localparam int PEAK_W   = 32;
  localparam int DNI_W    = 20;
  localparam int FLUX_W   = 24;
  localparam int LOSS_W   = 16;
  localparam int COS_W    = 16;
  localparam int THRESH_W = 32;
  localparam int ERR_W    = 48;

  // fixed-point formats
  localparam int ERR_FRAC   = 16;
  localparam int SCALE_FRAC = 24;
  localparam int SCALE_W    = 45;

  // parameter defaults
  localparam int STEPS_DEF      = 13;
  localparam int SIGMA_FRAC_DEF = 16;

  // search range is [0, SIGMA_LIMIT)
  localparam int SIGMA_LIMIT = 5;

  localparam logic [ERR_W-1:0] ERR_MAX   = '1;
  localparam logic [ERR_W-1:0] START_ERR = 48'h7FFF_FFFF_0000;

endpackage
`default_nettype wire

// ===== hw/rtl/bisf_mul.sv =====
// shared registered multiplier used for the scale and for squaring midpoints
`default_nettype none
module bisf_mul #(
  parameter int A_W = 45,
  parameter int B_W = 20
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bisf_div.sv =====
// restoring divider, one quotient bit per cycle, quotient saturated to the error range
`default_nettype none
module bisf_div #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 38,
  parameter int SHIFT = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [NUM_W-1:0]          num,
  input  wire logic [DEN_W-1:0]          den,
  output logic                           done,
  output logic [bisf_pkg::ERR_W-1:0]     quo
);
  import bisf_pkg::*;

  localparam int ITERS = NUM_W + SHIFT;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] numsh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [ERR_W-1:0] q;
  logic             ovf;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             take;
  logic [DEN_W-1:0] rem_next;

  // numsh fills with zeros, so after NUM_W bits the low dividend bits are zero
  always_comb begin
    rem_sh   = {rem, numsh[NUM_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, den_r};
    take     = ~diff[DEN_W+1];
    rem_next = take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= CNT_W'(ITERS);
      numsh <= num;
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
      den_r <= den;
    end else if (busy) begin
      cnt   <= cnt - CNT_W'(1);
      numsh <= {numsh[NUM_W-2:0], 1'b0};
      rem   <= rem_next;
      q     <= {q[ERR_W-2:0], take};
      // a one shifted out of the top means the quotient left the error range
      ovf   <= ovf | q[ERR_W-1];
    end
  end

  // zero divisor counts as saturated
  assign quo = (ovf || den_r == '0) ? ERR_MAX : q;

endmodule
`default_nettype wire

// ===== hw/rtl/bisection_inverse_square_fit.sv =====
// inverse-square scale fit by bisection of the spread over [0, 5)
// Usage:
//   input channel (in_valid/in_ready) takes one word: flux peak, irradiance,
//   flux factor, loss fraction and cosine. in_ready is high only while the
//   sequencer is idle; one word is worked on at a time.
//   output channel (out_valid/out_ready) returns fitted_sigma and best_error
//   from an output register, so the next input word may be accepted while a
//   result still waits.
//   cfg_write/cfg_data load the error threshold; the user writes it only while
//   the block is idle, which the block itself does not enforce.
// Sequence: the scale multiplies on the shared multiplier and a scale capture,
//   then per bisection step the midpoint, its square on the shared multiplier,
//   a one-bit-per-cycle divide, error, magnitude and update; a last state loads
//   the output. The serial divider dominates the fit time, and the next word is
//   taken in the idle state once the result is loaded.
// Reset (rst, synchronous) clears the threshold to zero, returns the
//   sequencer to idle and drops out_valid.
// A stalled receiver holds the result; a finished fit waits until the output
//   register is free.
`default_nettype none
module bisection_inverse_square_fit #(
  parameter int STEPS           = bisf_pkg::STEPS_DEF,
  parameter int SIGMA_FRAC_BITS = bisf_pkg::SIGMA_FRAC_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bisf_pkg::THRESH_W-1:0]   cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bisf_pkg::PEAK_W-1:0]     measured_peak,
  input  wire logic [bisf_pkg::DNI_W-1:0]      direct_irradiance,
  input  wire logic [bisf_pkg::FLUX_W-1:0]     flux_factor,
  input  wire logic [bisf_pkg::LOSS_W-1:0]     loss_fraction,
  input  wire logic signed [bisf_pkg::COS_W-1:0] cosine_factor,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [SIGMA_FRAC_BITS+2:0]           fitted_sigma,
  output logic [bisf_pkg::ERR_W-1:0]           best_error
);
  import bisf_pkg::*;

  localparam int SIGMA_W = SIGMA_FRAC_BITS + 3;
  localparam int DEN_W   = 2 * SIGMA_W;
  localparam int SHIFT   = 2 * SIGMA_FRAC_BITS + ERR_FRAC - SCALE_FRAC;
  localparam int MUL_A_W = SCALE_W;
  localparam int MUL_B_W = (SIGMA_W > DNI_W) ? SIGMA_W : DNI_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int EW      = ERR_W + 2;
  localparam int STEP_W  = $clog2(STEPS + 1);

  localparam logic [SIGMA_W-1:0] HIGH_INIT = SIGMA_W'(SIGMA_LIMIT) << SIGMA_FRAC_BITS;
  localparam logic [SIGMA_W-1:0] MID_INIT  = HIGH_INIT >> 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_FD,
    S_MUL_LOSS,
    S_MUL_COS,
    S_SCALE,
    S_MID,
    S_SQUARE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ERR,
    S_MAG,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state;

  logic [THRESH_W-1:0] thresh;
  logic [PEAK_W-1:0]   peak_r;
  logic [DNI_W-1:0]    dni_r;
  logic [FLUX_W-1:0]   flux_r;
  logic [LOSS_W-1:0]   loss_r;
  logic                cos_neg;
  logic [COS_W-1:0]    cos_mag;
  logic [SCALE_W-1:0]  pmag;
  logic [SIGMA_W-1:0]  low;
  logic [SIGMA_W-1:0]  high;
  logic [SIGMA_W-1:0]  mid;
  logic [SIGMA_W-1:0]  best_sig;
  logic [ERR_W-1:0]    best_err;
  logic [EW-1:0]       e_val;
  logic [ERR_W-1:0]    mag;
  logic                above;
  logic [STEP_W-1:0]   steps_left;

  logic [COS_W-1:0]    cos_abs;
  logic [LOSS_W:0]     one_minus_loss;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic                div_start;
  logic                div_done;
  logic [ERR_W-1:0]    div_quo;
  logic [EW-1:0]       e_abs;
  logic [ERR_W-1:0]    mag_next;
  logic                above_next;

  bisf_mul #(
    .A_W(MUL_A_W),
    .B_W(MUL_B_W)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  bisf_div #(
    .NUM_W(SCALE_W),
    .DEN_W(DEN_W),
    .SHIFT(SHIFT)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (pmag),
    .den  (mul_p[DEN_W-1:0]),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_DIV_GO);

  // magnitude of the Q1.15 cosine, full scale negative gives 32768
  assign cos_abs        = cosine_factor[COS_W-1] ? (~cosine_factor + 1'b1) : cosine_factor;
  assign one_minus_loss = {1'b1, {LOSS_W{1'b0}}} - {1'b0, loss_r};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_FD: begin
        mul_a = MUL_A_W'(flux_r);
        mul_b = MUL_B_W'(dni_r);
      end
      S_MUL_LOSS: begin
        mul_a = MUL_A_W'(mul_p[DNI_W+FLUX_W-1:0]);
        mul_b = MUL_B_W'(one_minus_loss);
      end
      S_MUL_COS: begin
        mul_a = mul_p[LOSS_W +: SCALE_W];
        mul_b = MUL_B_W'(cos_mag);
      end
      S_SQUARE: begin
        mul_a = MUL_A_W'(mid);
        mul_b = MUL_B_W'(mid);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // clamp to the error range and take the magnitude
  always_comb begin
    e_abs      = e_val[EW-1] ? (~e_val + 1'b1) : e_val;
    mag_next   = (e_abs > EW'(ERR_MAX)) ? ERR_MAX : e_abs[ERR_W-1:0];
    above_next = ~e_val[EW-1] && (e_val > EW'(thresh));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      thresh    <= '0;
    end else begin
      if (cfg_write) begin
        thresh <= cfg_data;
      end
      // the done state reloads the output itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            peak_r     <= measured_peak;
            dni_r      <= direct_irradiance;
            flux_r     <= flux_factor;
            loss_r     <= loss_fraction;
            cos_neg    <= cosine_factor[COS_W-1];
            cos_mag    <= cos_abs;
            low        <= '0;
            high       <= HIGH_INIT;
            best_sig   <= MID_INIT;
            best_err   <= START_ERR;
            steps_left <= STEP_W'(STEPS);
            state      <= S_MUL_FD;
          end
        end
        S_MUL_FD:   state <= S_MUL_LOSS;
        S_MUL_LOSS: state <= S_MUL_COS;
        S_MUL_COS:  state <= S_SCALE;
        S_SCALE: begin
          pmag  <= mul_p[COS_W-1 +: SCALE_W];
          state <= S_MID;
        end
        S_MID: begin
          mid   <= low + ((high - low) >> 1);
          state <= S_SQUARE;
        end
        S_SQUARE:   state <= S_DIV_GO;
        S_DIV_GO:   state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          // negative cosine makes the scale negative
          e_val <= cos_neg ? (EW'(peak_r) + EW'(div_quo)) : (EW'(peak_r) - EW'(div_quo));
          state <= S_MAG;
        end
        S_MAG: begin
          mag   <= mag_next;
          above <= above_next;
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          // strict compare keeps the earlier midpoint on ties
          if (mag < best_err) begin
            best_err <= mag;
            best_sig <= mid;
          end
          if (above) begin
            high <= mid;
          end else begin
            low <= mid;
          end
          steps_left <= steps_left - STEP_W'(1);
          if (steps_left == STEP_W'(1)) begin
            state <= S_DONE;
          end else begin
            state <= S_MID;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            fitted_sigma <= best_sig;
            best_error   <= best_err;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/bisect_fit_checker.sv =====
// checker for the bisection fit: predicts each fit from accepted words and compares results
module bisect_fit_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [bisf_pkg::THRESH_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [bisf_pkg::PEAK_W-1:0]   measured_peak,
  input  wire logic [bisf_pkg::DNI_W-1:0]    direct_irradiance,
  input  wire logic [bisf_pkg::FLUX_W-1:0]   flux_factor,
  input  wire logic [bisf_pkg::LOSS_W-1:0]   loss_fraction,
  input  wire logic [bisf_pkg::COS_W-1:0]    cosine_factor,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [bisf_pkg::SIGMA_FRAC_DEF+2:0] fitted_sigma,
  input  wire logic [bisf_pkg::ERR_W-1:0]    best_error,
  output int unsigned                        mismatches,
  output int unsigned                        fits_checked,
  output int unsigned                        fits_pending
);
  import bisf_pkg::*;

  localparam int STEPS     = STEPS_DEF;
  localparam int SIG_FRAC  = SIGMA_FRAC_DEF;
  localparam int SIG_W     = SIG_FRAC + 3;
  localparam int DIV_SHIFT = 2 * SIG_FRAC + ERR_FRAC - SCALE_FRAC;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [SIG_W-1:0] sigma;
    logic [ERR_W-1:0] err;
  } fit_t;

  fit_t                fits_due[$];
  logic [THRESH_W-1:0] threshold;

  function automatic fit_t predict_fit(input logic [PEAK_W-1:0]   peak,
                                       input logic [DNI_W-1:0]    dni,
                                       input logic [FLUX_W-1:0]   flux,
                                       input logic [LOSS_W-1:0]   loss,
                                       input logic [COS_W-1:0]    cos_raw,
                                       input logic [THRESH_W-1:0] thresh);
    logic             neg;
    logic [16:0]      cos_mag;
    logic [63:0]      scale;
    logic [63:0]      den;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [63:0]      mid;
    logic [127:0]     quo_wide;
    logic [ERR_W-1:0] quo;
    logic [ERR_W-1:0] mag;
    longint           e;
    longint           eps;
    longint           err_cap;
    fit_t             best;
    neg     = cos_raw[COS_W-1];
    cos_mag = neg ? 17'h10000 - {1'b0, cos_raw} : {1'b0, cos_raw};
    // scale magnitude stays in Q21.24, each product truncated
    scale = 64'(dni) * 64'(flux);
    scale = (scale * (64'h10000 - 64'(loss))) >> 16;
    scale = (scale * 64'(cos_mag)) >> 15;
    lo        = '0;
    hi        = 64'(SIGMA_LIMIT) << SIG_FRAC;
    best.sigma = SIG_W'(hi >> 1);
    best.err   = START_ERR;
    eps     = longint'({32'b0, thresh});
    err_cap = longint'({16'b0, ERR_MAX});
    for (int k = 0; k < STEPS; k++) begin
      mid = lo + ((hi - lo) >> 1);
      den = mid * mid;
      if (den == 0) begin
        quo = ERR_MAX;
      end else begin
        quo_wide = ({64'b0, scale} << DIV_SHIFT) / {64'b0, den};
        quo = (quo_wide > 128'(ERR_MAX)) ? ERR_MAX : quo_wide[ERR_W-1:0];
      end
      // negative cosine flips the sign of the scale
      if (neg) begin
        e = longint'({32'b0, peak}) + longint'({16'b0, quo});
      end else begin
        e = longint'({32'b0, peak}) - longint'({16'b0, quo});
      end
      if (e > err_cap) e = err_cap;
      if (e < -err_cap) e = -err_cap;
      mag = ERR_W'((e < 0) ? -e : e);
      // strict compare keeps the earlier midpoint on ties
      if (mag < best.err) begin
        best.err   = mag;
        best.sigma = SIG_W'(mid);
      end
      if (e > eps) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    return best;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch on %0s: got %0h, expected %0h (result %0d)",
               what, got, want, fits_checked);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    fit_t want;
    if (rst) begin
      threshold    = '0;
      mismatches   = 0;
      fits_checked = 0;
      fits_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        fits_due.insert(fits_due.size(),
                        predict_fit(measured_peak, direct_irradiance, flux_factor,
                                    loss_fraction, cosine_factor, threshold));
      end
      if (out_valid && out_ready) begin
        if (fits_due.size() == 0) begin
          report("unexpected result word", {45'b0, fitted_sigma}, '0);
        end else begin
          want = fits_due.pop_front();
          if (fitted_sigma !== want.sigma) begin
            report("fitted_sigma", {45'b0, fitted_sigma}, {45'b0, want.sigma});
          end
          if (best_error !== want.err) begin
            report("best_error", {16'b0, best_error}, {16'b0, want.err});
          end
        end
        fits_checked++;
      end
      if (cfg_write) threshold = cfg_data;
    end
    fits_pending = fits_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// top of the bisection fit testbench: clock, reset, stimulus, output stalls and verdict
module tb;
  import bisf_pkg::*;

  localparam int SIG_W        = SIGMA_FRAC_DEF + 3;
  localparam int FIT_LATENCY  = 4 + STEPS_DEF * (2 * SIGMA_FRAC_DEF + 44) + 1;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 290;
  localparam int QUIET_WORDS  = 200;
  localparam int STALL_CYCLES = 2500;
  localparam int CYCLE_LIMIT  = 6000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [THRESH_W-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PEAK_W-1:0]     measured_peak = '0;
  logic [DNI_W-1:0]      direct_irradiance = '0;
  logic [FLUX_W-1:0]     flux_factor = '0;
  logic [LOSS_W-1:0]     loss_fraction = '0;
  logic signed [COS_W-1:0] cosine_factor = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SIG_W-1:0]      fitted_sigma;
  logic [ERR_W-1:0]      best_error;

  int unsigned mismatches;
  int unsigned fits_checked;
  int unsigned fits_pending;
  int unsigned words_sent = 0;
  int unsigned settings_used = 0;
  int unsigned stall_ask = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bisection_inverse_square_fit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .measured_peak     (measured_peak),
    .direct_irradiance (direct_irradiance),
    .flux_factor       (flux_factor),
    .loss_fraction     (loss_fraction),
    .cosine_factor     (cosine_factor),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .fitted_sigma      (fitted_sigma),
    .best_error        (best_error)
  );

  bisect_fit_checker fit_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .measured_peak     (measured_peak),
    .direct_irradiance (direct_irradiance),
    .flux_factor       (flux_factor),
    .loss_fraction     (loss_fraction),
    .cosine_factor     (cosine_factor),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .fitted_sigma      (fitted_sigma),
    .best_error        (best_error),
    .mismatches        (mismatches),
    .fits_checked      (fits_checked),
    .fits_pending      (fits_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, fits_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // random width so small and large magnitudes both show up
  function automatic logic [31:0] rand_bits(input int width);
    int w;
    w = ($urandom_range(0, 3) == 0) ? width : $urandom_range(1, width);
    return $urandom & 32'((64'd1 << w) - 1);
  endfunction

  // peak that puts the best fit near sigma = milli / 1000
  function automatic logic [31:0] fit_peak(input int unsigned milli, input logic [19:0] dni,
                                           input logic [23:0] flux, input logic [15:0] loss,
                                           input logic signed [15:0] cosv);
    real p;
    real s;
    real q;
    p = real'(dni) / 256.0 * real'(flux) / 65536.0 * (1.0 - real'(loss) / 65536.0)
        * real'(cosv) / 32768.0;
    if (p < 0.0) p = -p;
    s = real'(milli) / 1000.0;
    q = p / (s * s) * 65536.0;
    if (q >= 4294967295.0) return '1;
    return 32'(longint'(q));
  endfunction

  task automatic send_word(input logic [31:0] peak, input logic [19:0] dni,
                           input logic [23:0] flux, input logic [15:0] loss,
                           input logic signed [15:0] cosv);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    measured_peak     <= peak;
    direct_irradiance <= dni;
    flux_factor       <= flux;
    loss_fraction     <= loss;
    cosine_factor     <= cosv;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // drop valid and wait until every predicted fit has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (fits_pending != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // output side: random stall bursts, one long hold on request
  initial begin : receiver
    int unsigned stall_seen;
    int          hold_left;
    int          burst_left;
    stall_seen = 0;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (stall_ask != stall_seen) begin
        stall_seen = stall_ask;
        hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        out_ready <= 1'b0;
        burst_left--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) burst_left = $urandom_range(1, 12);
      end
    end
  end

  initial begin : stimulus
    logic [31:0]        thresholds [PHASES];
    logic [31:0]        peak;
    logic [19:0]        dni;
    logic [23:0]        flux;
    logic [15:0]        loss;
    logic signed [15:0] cosv;
    thresholds = '{32'hFFFF_FFFF, 32'h0, 32'($urandom_range(0, 65535)), $urandom,
                   32'h1, 32'h0010_0000};
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, saturation, sign of the cosine, fits near the range ends
    write_threshold(32'h0);
    send_word('0, '0, '0, '0, '0);
    send_word('1, '1, '1, '0, 16'sh7FFF);
    send_word('1, '1, '1, '0, -16'sh8000);
    send_word('0, '1, '1, '0, -16'sh8000);
    send_word('1, '1, '1, '1, 16'sh7FFF);
    send_word(32'h00BC_614E, 20'h12345, 24'h00ABCD, 16'h4000, '0);
    send_word(32'h0001_0000, 20'h00100, 24'h010000, 16'h0000, -16'sh0001);
    send_word('0, 20'h00400, 24'h020000, 16'h1000, 16'sh4000);
    send_word('1, 20'h00001, 24'h000001, 16'h0000, 16'sh0001);
    send_word(32'h0000_FFFF, '1, '0, 16'h8000, 16'sh2000);
    send_word(fit_peak(1000, 20'h01000, 24'h010000, 16'h0000, 16'sh7FFF),
              20'h01000, 24'h010000, 16'h0000, 16'sh7FFF);
    send_word(fit_peak(4990, 20'h00800, 24'h030000, 16'h2000, 16'sh6000),
              20'h00800, 24'h030000, 16'h2000, 16'sh6000);
    send_word(fit_peak(1, 20'h00100, 24'h000100, 16'h0000, 16'sh7FFF),
              20'h00100, 24'h000100, 16'h0000, 16'sh7FFF);
    send_word(fit_peak(2500, 20'h00200, 24'h008000, 16'hF000, 16'sh1000),
              20'h00200, 24'h008000, 16'hF000, 16'sh1000);
    send_word(32'hFFFF_0000, 20'h80000, 24'h800000, 16'h8000, -16'sh4000);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_threshold(thresholds[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        quiet = (p == PHASES - 1) && (i >= PHASE_WORDS - QUIET_WORDS);
        // long receiver hold while words keep coming
        if (p == 1 && i == 20) stall_ask++;
        if (p == 3 && i == 100) drain();
        if ($urandom_range(0, 9) < 7) begin
          dni  = rand_bits(20) | 20'h1;
          flux = rand_bits(24) | 24'h1;
          loss = rand_bits(16);
          cosv = 16'($urandom_range(1, 32767));
          peak = fit_peak($urandom_range(1, 4999), dni, flux, loss, cosv)
                 ^ ($urandom & 32'h3F);
        end else begin
          peak = rand_bits(32);
          dni  = rand_bits(20);
          flux = rand_bits(24);
          loss = rand_bits(16);
          cosv = 16'($urandom);
        end
        send_word(peak, dni, flux, loss, cosv);
      end
    end

    drain();
    repeat (FIT_LATENCY) @(negedge clk);
    $display("covered %0d words, %0d results checked, over %0d threshold settings",
             words_sent, fits_checked, settings_used);
    $display("included a %0d-cycle output hold, a drain pause and a closing run without gaps",
             STALL_CYCLES);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
